@@ src/rlpw_pkg.sv @@
// Shared widths, register indexes and pipeline word type for the radial lens warp.
package rlpw_pkg;

   localparam int CW    = 24;          // coordinate width
   localparam int RW    = CW - 1;      // radius width
   localparam int SW    = 16;          // strength width, Q2.14
   localparam int RTW   = RW + 1;      // square root width
   localparam int D2W   = 2 * RW + 1;  // sum of squares width
   localparam int PW1   = SW + RW;     // strength times delta
   localparam int NUMW  = PW1 + RW;    // full numerator
   localparam int DENW  = RW + 14;     // radius << 14
   localparam int QW    = RW + 2;      // quotient width
   localparam int CSRW  = CW;          // config data width
   localparam int CSRIW = 2;           // config index width

   localparam logic [CSRIW-1:0] CSR_CENTER_X  = CSRIW'(0);
   localparam logic [CSRIW-1:0] CSR_CENTER_Y  = CSRIW'(1);
   localparam logic [CSRIW-1:0] CSR_RADIUS    = CSRIW'(2);
   localparam logic [CSRIW-1:0] CSR_STRENGTH  = CSRIW'(3);

   localparam logic [RW-1:0] RADIUS_RESET   = RW'(25600);
   localparam logic [SW-1:0] STRENGTH_RESET = SW'(16384);

   // per-point word carried down the pipeline
   typedef struct packed {
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic [RW-1:0]        adx;
      logic [RW-1:0]        ady;
      logic                 nx;
      logic                 ny;
      logic                 cand;
   } carry_type;

endpackage

@@ src/radial_lens_point_warp.sv @@
// Radial lens point warp: fully pipelined datapath with config registers.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  request | req_point_x, req_point_y                | start && !busy
//  result  | rsp_warped_x, rsp_warped_y,             | rsp_valid, one cycle
//          | rsp_inside_lens                         |
//  config  | csr_index, csr_wdata                    | csr_we
//
// One word per clock; busy is always low. Stages in order: input, abs, square, sum,
// one square root stage per root bit, length, two multiplies, divider load, one
// divider stage per quotient bit (both axes in the same stage), output.
// Synchronous reset clears all valid bits and loads register defaults.
// The receiver cannot stall, so the pipeline advances every cycle.
module radial_lens_point_warp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [rlpw_pkg::CW-1:0] req_point_x,
   input  logic signed [rlpw_pkg::CW-1:0] req_point_y,
   output logic                           rsp_valid,
   output logic signed [rlpw_pkg::CW-1:0] rsp_warped_x,
   output logic signed [rlpw_pkg::CW-1:0] rsp_warped_y,
   output logic                           rsp_inside_lens,
   input  logic                           csr_we,
   input  logic [rlpw_pkg::CSRIW-1:0]     csr_index,
   input  logic [rlpw_pkg::CSRW-1:0]      csr_wdata
);
   import rlpw_pkg::*;

   localparam int LAT_C = RTW + QW + 9;

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW+1:0] v);
      logic signed [CW+1:0] hi;
      logic signed [CW+1:0] lo;
      hi = (CW+2)'((64'sd1 <<< (CW-1)) - 64'sd1);
      lo = -hi - (CW+2)'(1);
      if (v > hi) return hi[CW-1:0];
      else if (v < lo) return lo[CW-1:0];
      else return v[CW-1:0];
   endfunction

   // configuration
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [RW-1:0]        rad_ff;
   logic signed [SW-1:0] ws_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         rad_ff <= RADIUS_RESET;
         ws_ff  <= STRENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: cx_ff  <= csr_wdata[CW-1:0];
            CSR_CENTER_Y: cy_ff  <= csr_wdata[CW-1:0];
            CSR_RADIUS:   rad_ff <= csr_wdata[RW-1:0];
            CSR_STRENGTH: ws_ff  <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [SW-1:0] as_w;
   logic          wneg_w;
   assign wneg_w = ws_ff[SW-1];
   assign as_w   = wneg_w ? SW'(-ws_ff) : SW'(ws_ff);

   // input stage
   logic                 in_v_ff;
   logic signed [CW-1:0] in_px_ff, in_py_ff;

   always_ff @(posedge clock) begin
      if (reset) in_v_ff <= 1'b0;
      else in_v_ff <= start && !busy;
      in_px_ff <= req_point_x;
      in_py_ff <= req_point_y;
   end

   // deltas and the inside-box test
   logic signed [CW:0] dx_w, dy_w;
   logic [CW:0]        adx_w, ady_w;
   carry_type          b_in, b_ff;
   logic               b_v_ff;

   always_comb begin
      dx_w  = (CW+1)'(in_px_ff) - (CW+1)'(cx_ff);
      dy_w  = (CW+1)'(in_py_ff) - (CW+1)'(cy_ff);
      adx_w = dx_w[CW] ? (CW+1)'(-dx_w) : (CW+1)'(dx_w);
      ady_w = dy_w[CW] ? (CW+1)'(-dy_w) : (CW+1)'(dy_w);
      b_in.px   = in_px_ff;
      b_in.py   = in_py_ff;
      b_in.adx  = adx_w[RW-1:0];
      b_in.ady  = ady_w[RW-1:0];
      b_in.nx   = dx_w[CW];
      b_in.ny   = dy_w[CW];
      b_in.cand = (rad_ff != '0) && (adx_w < (CW+1)'(rad_ff)) && (ady_w < (CW+1)'(rad_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else b_v_ff <= in_v_ff;
      b_ff <= b_in;
   end

   // squares
   logic            c_v_ff;
   carry_type       c_ff;
   logic [2*RW-1:0] sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else c_v_ff <= b_v_ff;
      c_ff   <= b_ff;
      sqx_ff <= b_ff.adx * b_ff.adx;
      sqy_ff <= b_ff.ady * b_ff.ady;
   end

   // square root: stage 0 holds the sum, one root bit per stage after it
   logic             sq_v_ff    [RTW+1];
   carry_type        sq_c_ff    [RTW+1];
   logic [RTW-1:0]   sq_root_ff [RTW+1];
   logic [D2W-1:0]   sq_rem_ff  [RTW+1];

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else sq_v_ff[0] <= c_v_ff;
      sq_c_ff[0]    <= c_ff;
      sq_root_ff[0] <= '0;
      sq_rem_ff[0]  <= D2W'(sqx_ff) + D2W'(sqy_ff);
   end

   for (genvar k = 0; k < RTW; k++) begin : g_sqrt
      localparam int BI = RTW - 1 - k;
      logic [D2W:0] trial_w;
      logic         take_w;
      assign trial_w = ((D2W+1)'(sq_root_ff[k]) << (BI + 1)) | ((D2W+1)'(1) << (2 * BI));
      assign take_w  = (D2W+1)'(sq_rem_ff[k]) >= trial_w;
      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[k+1] <= 1'b0;
         else sq_v_ff[k+1] <= sq_v_ff[k];
         sq_c_ff[k+1] <= sq_c_ff[k];
         if (take_w) begin
            sq_rem_ff[k+1]  <= D2W'((D2W+1)'(sq_rem_ff[k]) - trial_w);
            sq_root_ff[k+1] <= sq_root_ff[k] | (RTW'(1) << BI);
         end else begin
            sq_rem_ff[k+1]  <= sq_rem_ff[k];
            sq_root_ff[k+1] <= sq_root_ff[k];
         end
      end
   end

   // remaining length and inside decision
   logic          e_v_ff, e_inside_ff;
   carry_type     e_c_ff;
   logic [RW-1:0] e_len_ff;

   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else e_v_ff <= sq_v_ff[RTW];
      e_c_ff      <= sq_c_ff[RTW];
      e_inside_ff <= sq_c_ff[RTW].cand && (sq_root_ff[RTW] < RTW'(rad_ff));
      e_len_ff    <= RW'(rad_ff - sq_root_ff[RTW][RW-1:0]);
   end

   // strength times delta
   logic           f_v_ff, f_inside_ff;
   carry_type      f_c_ff;
   logic [RW-1:0]  f_len_ff;
   logic [PW1-1:0] f_px_ff, f_py_ff;

   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else f_v_ff <= e_v_ff;
      f_c_ff      <= e_c_ff;
      f_inside_ff <= e_inside_ff;
      f_len_ff    <= e_len_ff;
      f_px_ff     <= as_w * e_c_ff.adx;
      f_py_ff     <= as_w * e_c_ff.ady;
   end

   // times length, plus half the divisor for rounding
   logic            g_v_ff, g_inside_ff;
   carry_type       g_c_ff;
   logic [NUMW-1:0] g_nx_ff, g_ny_ff, half_w;

   assign half_w = NUMW'(rad_ff) << 13;

   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else g_v_ff <= f_v_ff;
      g_c_ff      <= f_c_ff;
      g_inside_ff <= f_inside_ff;
      g_nx_ff     <= NUMW'(f_px_ff * f_len_ff) + half_w;
      g_ny_ff     <= NUMW'(f_py_ff * f_len_ff) + half_w;
   end

   // restoring divider, one quotient bit per stage per axis
   logic [DENW-1:0] den_w;
   assign den_w = DENW'(rad_ff) << 14;

   logic            dv_v_ff      [QW+1];
   logic            dv_inside_ff [QW+1];
   carry_type       dv_c_ff      [QW+1];
   logic [NUMW-1:0] dv_nx_ff     [QW+1];
   logic [NUMW-1:0] dv_ny_ff     [QW+1];
   logic [DENW-1:0] dv_rx_ff     [QW+1];
   logic [DENW-1:0] dv_ry_ff     [QW+1];
   logic [QW-1:0]   dv_qx_ff     [QW+1];
   logic [QW-1:0]   dv_qy_ff     [QW+1];

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else dv_v_ff[0] <= g_v_ff;
      dv_inside_ff[0] <= g_inside_ff;
      dv_c_ff[0]      <= g_c_ff;
      dv_nx_ff[0]     <= g_nx_ff;
      dv_ny_ff[0]     <= g_ny_ff;
      dv_rx_ff[0]     <= DENW'(g_nx_ff >> QW);
      dv_ry_ff[0]     <= DENW'(g_ny_ff >> QW);
      dv_qx_ff[0]     <= '0;
      dv_qy_ff[0]     <= '0;
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int BI = QW - 1 - k;
      logic [DENW:0] tx_w, ty_w;
      logic          gex_w, gey_w;
      assign tx_w  = {dv_rx_ff[k], dv_nx_ff[k][BI]};
      assign ty_w  = {dv_ry_ff[k], dv_ny_ff[k][BI]};
      assign gex_w = tx_w >= (DENW+1)'(den_w);
      assign gey_w = ty_w >= (DENW+1)'(den_w);
      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[k+1] <= 1'b0;
         else dv_v_ff[k+1] <= dv_v_ff[k];
         dv_inside_ff[k+1] <= dv_inside_ff[k];
         dv_c_ff[k+1]      <= dv_c_ff[k];
         dv_nx_ff[k+1]     <= dv_nx_ff[k];
         dv_ny_ff[k+1]     <= dv_ny_ff[k];
         dv_rx_ff[k+1] <= gex_w ? DENW'(tx_w - (DENW+1)'(den_w)) : DENW'(tx_w);
         dv_ry_ff[k+1] <= gey_w ? DENW'(ty_w - (DENW+1)'(den_w)) : DENW'(ty_w);
         dv_qx_ff[k+1] <= dv_qx_ff[k] | (QW'(gex_w) << BI);
         dv_qy_ff[k+1] <= dv_qy_ff[k] | (QW'(gey_w) << BI);
      end
   end

   // apply offset and saturate
   logic signed [CW+1:0] offx_w, offy_w, ox_w, oy_w;
   carry_type            fin_c;

   always_comb begin
      fin_c  = dv_c_ff[QW];
      offx_w = (CW+2)'(dv_qx_ff[QW]);
      offy_w = (CW+2)'(dv_qy_ff[QW]);
      if (fin_c.nx ^ wneg_w) offx_w = -offx_w;
      if (fin_c.ny ^ wneg_w) offy_w = -offy_w;
      ox_w = (CW+2)'(fin_c.px) - offx_w;
      oy_w = (CW+2)'(fin_c.py) - offy_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid       <= 1'b0;
         rsp_inside_lens <= 1'b0;
      end else begin
         rsp_valid       <= dv_v_ff[QW];
         rsp_inside_lens <= dv_v_ff[QW] && dv_inside_ff[QW];
      end
      rsp_warped_x <= dv_inside_ff[QW] ? sat_coord(ox_w) : fin_c.px;
      rsp_warped_y <= dv_inside_ff[QW] ? sat_coord(oy_w) : fin_c.py;
   end

   // a word that was not moved leaves exactly as it came in
   a_pass_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_lens) |-> rsp_warped_x == $past(req_point_x, LAT_C))
      else $error("unmoved point x changed");

   a_pass_y: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_lens) |-> rsp_warped_y == $past(req_point_y, LAT_C))
      else $error("unmoved point y changed");

   a_inside_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_inside_lens |-> rsp_valid)
      else $error("inside flag without result strobe");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (e_v_ff && e_inside_ff) |-> e_len_ff != '0)
      else $error("inside point with zero remaining length");

endmodule

@@ test/radial_lens_point_warp_test.sv @@
// Self-checking testbench for the radial lens point warp.
module radial_lens_point_warp_test;
   import rlpw_pkg::*;

   localparam int LATENCY = RTW + QW + 9;
   localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;

   typedef struct {
      logic signed [CW-1:0] wx;
      logic signed [CW-1:0] wy;
      logic                 in_lens;
   } warp_word_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CW-1:0] req_point_x = '0;
   logic signed [CW-1:0] req_point_y = '0;
   logic rsp_valid;
   logic signed [CW-1:0] rsp_warped_x;
   logic signed [CW-1:0] rsp_warped_y;
   logic rsp_inside_lens;
   logic csr_we = 0;
   logic [CSRIW-1:0] csr_index = '0;
   logic [CSRW-1:0] csr_wdata = '0;

   longint lens_cx, lens_cy, lens_r, lens_k;
   warp_word_type pending_warps[$];
   int mismatches = 0;
   longint cycles = 0;
   localparam longint CYCLE_LIMIT = 400000;

   radial_lens_point_warp dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatches++;
   endtask

   // floor square root, one result bit at a time (v < 2^48)
   function automatic longint isqrt(input longint v);
      longint r;
      longint b;
      r = 0;
      for (int i = 24; i >= 0; i--) begin
         b = r | (64'sd1 <<< i);
         if (b * b <= v) r = b;
      end
      return r;
   endfunction

   // offset = round(k*delta*len/(r<<14)), ties away from zero
   function automatic longint lens_offset(input longint delta, input longint len);
      longint ad, ak, den, q;
      bit neg;
      ad = delta < 0 ? -delta : delta;
      ak = lens_k < 0 ? -lens_k : lens_k;
      neg = (delta < 0) != (lens_k < 0);
      den = lens_r << 14;
      // ak*ad < 2^38, len < 2^23: fits in 128-bit math via two steps
      q = longint'(((128'(ak * ad) * 128'(len)) + 128'(den >> 1)) / 128'(den));
      return neg ? -q : q;
   endfunction

   function automatic longint sat(input longint v);
      return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
   endfunction

   function automatic warp_word_type predict_warp(input longint px, input longint py);
      warp_word_type w;
      longint dx, dy, adx, ady, d;
      longint ox = px, oy = py;
      bit in_lens = 0;
      dx = px - lens_cx;
      dy = py - lens_cy;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (lens_r != 0 && adx < lens_r && ady < lens_r) begin
         d = isqrt(adx * adx + ady * ady);
         if (d < lens_r) begin
            in_lens = 1;
            ox = px - lens_offset(dx, lens_r - d);
            oy = py - lens_offset(dy, lens_r - d);
         end
      end
      w.wx = CW'(sat(ox));
      w.wy = CW'(sat(oy));
      w.in_lens = in_lens;
      return w;
   endfunction

   always @(posedge clock) begin
      warp_word_type w;
      if (!reset && rsp_valid) begin
         if (pending_warps.size() == 0) begin
            report("unexpected word", 1, 0);
         end else begin
            w = pending_warps.pop_front();
            if (rsp_warped_x !== w.wx) report("warped_x", rsp_warped_x, w.wx);
            if (rsp_warped_y !== w.wy) report("warped_y", rsp_warped_y, w.wy);
            if (rsp_inside_lens !== w.in_lens)
               report("inside_lens", rsp_inside_lens, w.in_lens);
         end
      end
   end

   task automatic send_point(input longint px, input longint py);
      @(negedge clock);
      start <= 1;
      req_point_x <= CW'(px);
      req_point_y <= CW'(py);
      do @(posedge clock); while (busy);
      pending_warps.push_back(predict_warp(px, py));
   endtask

   task automatic idle(input int n);
      @(negedge clock);
      start <= 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      idle(0);
      while (pending_warps.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSRIW-1:0] idx, input longint v);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= CSRW'(v);
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_CENTER_X: lens_cx = longint'(signed'(CW'(v)));
         CSR_CENTER_Y: lens_cy = longint'(signed'(CW'(v)));
         CSR_RADIUS:   lens_r = v & ((64'd1 << RW) - 1);
         CSR_STRENGTH: lens_k = longint'(signed'(SW'(v)));
         default: ;
      endcase
   endtask

   task automatic set_lens(input longint cx, input longint cy, input longint r,
                           input longint k);
      drain();
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_RADIUS, r);
      write_csr(CSR_STRENGTH, k);
   endtask

   task automatic test_reset_defaults();
      send_point(0, 0);
      send_point(100 * 256, 0);
      send_point(50 * 256, -30 * 256);
      send_point(99 * 256, 5);
      send_point(CMAX, CMIN);
   endtask

   task automatic test_directed();
      // rim: d equal to radius passes
      set_lens(0, 0, 1000, 16384);
      send_point(600, 800);
      send_point(599, 800);
      send_point(1000, 0);
      send_point(-999, 0);
      // zero radius: nothing inside
      set_lens(0, 0, 0, 16384);
      send_point(0, 0);
      send_point(5, -5);
      // saturation near the edges, extreme strength and radius
      set_lens(CMAX, CMIN, (64'd1 << RW) - 1, -32768);
      send_point(CMAX, CMIN);
      send_point(CMAX - 5000000, CMIN + 300);
      send_point(CMIN, CMAX);
      set_lens(CMIN, CMAX, (64'd1 << RW) - 1, 32767);
      send_point(CMIN + 4000000, CMAX - 4000000);
      send_point(CMIN, CMAX);
      send_point(0, 0);
      set_lens(-12345, 777, 1, 0);
      send_point(-12345, 777);
      send_point(-12344, 777);
   endtask

   task automatic test_random();
      int sent = 0;
      int burst;
      longint span;
      for (int phase = 0; phase < 6; phase++) begin
         span = (phase == 5) ? (64'd1 << RW) - 1 : longint'($urandom_range(1, 200000));
         set_lens(longint'(signed'(CW'($urandom()))), longint'(signed'(CW'($urandom()))),
                  span, longint'(signed'(SW'($urandom()))));
         for (int i = 0; i < 140; i++) begin
            case ($urandom_range(0, 3))
               0: send_point(longint'(signed'(CW'($urandom()))),
                             longint'(signed'(CW'($urandom()))));
               default: send_point(
                  sat(lens_cx + $signed($urandom_range(0, 2 * span)) - span),
                  sat(lens_cy + $signed($urandom_range(0, 2 * span)) - span));
            endcase
            sent++;
            burst = $urandom_range(0, 7);
            if (burst == 0) idle($urandom_range(1, 6));
         end
         // wait until every expected word has come once in the run
         if (phase == 2) begin
            idle(0);
            while (pending_warps.size() != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      lens_cx = 0;
      lens_cy = 0;
      lens_r = 25600;
      lens_k = 16384;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_reset_defaults();
      test_directed();
      test_random();
      drain();
      if (mismatches == 0 && pending_warps.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
